### design/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants of the bounded stack with search.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int POS_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_MODIFY  = 3'd3,
        CMD_DISPLAY = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_SHOW
    } state_t;

    // One queued command between the front and the back.
    typedef struct packed {
        cmd_t                     cmd;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] new_value;
    } q_entry_t;

endpackage

`default_nettype wire

### design/bss_front.sv
// ----------------------------------------------------------------------------
// bss_front
// Accepts command words, drops unused command codes and queues the rest
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_front
    import bss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [WORD_W-1:0] value,
    input  logic signed [WORD_W-1:0] new_value,
    output logic                     q_valid,
    input  logic                     q_take,
    output q_entry_t                 q_entry
);

    q_entry_t   slot_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic       known;
    logic       push;
    logic       pop;
    q_entry_t   entry;

    assign in_stall = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = slot_reg[rd_ptr_reg];

    // Codes above display are taken from the port and simply vanish.
    assign known = (command <= CMD_DISPLAY);
    assign push  = in_valid && !in_stall && known;
    assign pop   = q_take && q_valid;

    always_comb
    begin
        entry.cmd       = cmd_t'(command);
        entry.value     = value;
        entry.new_value = new_value;
    end

    always_comb
    begin
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

### design/bss_back.sv
// ----------------------------------------------------------------------------
// bss_back
// Executes queued commands against the stack memory and drives the
// registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_back
    import bss_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_take,
    input  q_entry_t                 q_entry,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic signed [WORD_W-1:0] word,
    output logic [POS_W-1:0]         position,
    output logic                     last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [WORD_W-1:0] stack_mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CW-1:0]            fill_reg;
    logic [CW-1:0]            fill_next;
    logic [AW-1:0]            idx_reg;
    logic [AW-1:0]            idx_next;
    logic signed [WORD_W-1:0] value_reg;
    logic signed [WORD_W-1:0] value_next;
    logic signed [WORD_W-1:0] nval_reg;
    logic signed [WORD_W-1:0] nval_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  out_status_reg;
    status_t                  out_status_next;
    logic signed [WORD_W-1:0] out_word_reg;
    logic signed [WORD_W-1:0] out_word_next;
    logic [POS_W-1:0]         out_pos_reg;
    logic [POS_W-1:0]         out_pos_next;
    logic                     out_last_reg;
    logic                     out_last_next;
    logic                     out_load;

    logic                     mem_we;
    logic [AW-1:0]            wr_addr;
    logic signed [WORD_W-1:0] wr_data;

    logic                     out_free;
    logic                     empty;
    logic                     full;
    logic [AW-1:0]            top_idx;
    logic                     match;
    logic                     at_end;

    assign out_free = !out_valid_reg || !out_stall;
    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == CW'(DEPTH));
    assign top_idx  = AW'(fill_reg - CW'(1));
    assign match    = (rd_data_reg == value_reg);
    assign at_end   = (idx_reg == top_idx);

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign word      = out_word_reg;
    assign position  = out_pos_reg;
    assign last      = out_last_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free && !empty)
                begin
                    case (q_entry.cmd)
                        CMD_POP:     state_next = S_READ;
                        CMD_PEEK:    state_next = S_READ;
                        CMD_MODIFY:  state_next = S_SEARCH;
                        CMD_DISPLAY: state_next = S_SHOW;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (out_free && (match || at_end))
                begin
                    state_next = S_IDLE;
                end
            end
            S_SHOW:
            begin
                if (out_free && (idx_reg == '0))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs. The read address is always idx_next, so the
    // registered read data holds the entry at idx_reg in the next cycle.
    always_comb
    begin
        q_take          = 1'b0;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        value_next      = value_reg;
        nval_next       = nval_reg;
        mem_we          = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = nval_reg;
        out_load        = 1'b0;
        out_status_next = ST_OK;
        out_word_next   = rd_data_reg;
        out_pos_next    = POS_W'(idx_reg);
        out_last_next   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_take     = 1'b1;
                    value_next = q_entry.value;
                    nval_next  = q_entry.new_value;
                    if (q_entry.cmd == CMD_PUSH)
                    begin
                        out_load = 1'b1;
                        if (full)
                        begin
                            out_status_next = ST_OVERFLOW;
                            out_word_next   = '0;
                            out_pos_next    = '0;
                        end
                        else
                        begin
                            mem_we        = 1'b1;
                            wr_addr       = AW'(fill_reg);
                            wr_data       = q_entry.value;
                            out_word_next = q_entry.value;
                            out_pos_next  = POS_W'(fill_reg);
                            fill_next     = fill_reg + CW'(1);
                        end
                    end
                    else if (empty)
                    begin
                        out_load        = 1'b1;
                        out_status_next = ST_UNDERFLOW;
                        out_word_next   = '0;
                        out_pos_next    = '0;
                    end
                    else
                    begin
                        case (q_entry.cmd)
                            CMD_POP:
                            begin
                                idx_next  = top_idx;
                                fill_next = fill_reg - CW'(1);
                            end
                            CMD_PEEK:    idx_next = top_idx;
                            CMD_MODIFY:  idx_next = '0;
                            CMD_DISPLAY: idx_next = top_idx;
                            default:     idx_next = idx_reg;
                        endcase
                    end
                end
            end
            S_READ:
            begin
                out_load = out_free;
            end
            S_SEARCH:
            begin
                if (out_free && match)
                begin
                    out_load      = 1'b1;
                    mem_we        = 1'b1;
                    out_word_next = nval_reg;
                end
                else if (out_free && at_end)
                begin
                    out_load        = 1'b1;
                    out_status_next = ST_NOTFOUND;
                    out_word_next   = '0;
                    out_pos_next    = '0;
                end
                else if (!match && !at_end)
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_SHOW:
            begin
                out_last_next = (idx_reg == '0);
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (idx_reg != '0)
                    begin
                        idx_next = idx_reg - AW'(1);
                    end
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        nval_reg  <= nval_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_word_reg   <= out_word_next;
            out_pos_reg    <= out_pos_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stack_mem[idx_next];
    end

endmodule

`default_nettype wire

### design/bounded_stack_with_search_top.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top
// LIFO stack of DEPTH signed words with push, pop, peek, modify and display.
// ----------------------------------------------------------------------------
// Commands pass through a two-word queue to a back end that owns a stack
// memory with one write port and one registered read port, and results leave
// through an output register, so either side may stall on its own. Push,
// overflow and underflow results are loaded straight from the queue entry;
// pop and peek first wait for the registered memory read. Modify compares one
// stored word per cycle from the bottom until a match or the top of the stack.
// Display emits one word per cycle from the top while the output is not
// stalled. Codes 5 to 7 are accepted and give no result. The memory needs no
// clearing pass after reset.
`default_nettype none

module bounded_stack_with_search_top
    import bss_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [WORD_W-1:0] value,
    input  logic signed [WORD_W-1:0] new_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic signed [WORD_W-1:0] word,
    output logic [POS_W-1:0]         position,
    output logic                     last
);

    logic     q_valid;
    logic     q_take;
    q_entry_t q_entry;

    bss_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .value     (value),
        .new_value (new_value),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_entry   (q_entry)
    );

    bss_back #(
        .DEPTH (DEPTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_entry   (q_entry),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .word      (word),
        .position  (position),
        .last      (last)
    );

endmodule

`default_nettype wire

### design/bss_checker.sv
// ----------------------------------------------------------------------------
// bss_checker
// Port-level checks of the stack results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_checker
    import bss_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [STAT_W-1:0]        status,
    input logic signed [WORD_W-1:0] word,
    input logic [POS_W-1:0]         position,
    input logic                     last
);

    // A stalled result word holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(word)
            && $stable(position) && $stable(last))
        else $error("result word changed while stalled");

    // Every error is a single result and closes its command.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> last)
        else $error("error result without last");

    // Error results carry a zero word at position zero.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (word == '0) && (position == '0))
        else $error("error result with nonzero payload");

    // Only a display run produces words before the last one, so they must
    // carry an OK status; the run never reaches position zero before it ends.
    a_run_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> (status == ST_OK))
        else $error("unfinished run with error status");

endmodule

bind bounded_stack_with_search_top bss_checker u_bss_checker (.*);

`default_nettype wire
